>>> rtl/tlc_pkg.sv
// Shared types and constants for the token lexer.
`timescale 1ns / 1ps

package tlc_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int OFFSET_WIDTH   = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] IDENT_LEAD   = 8'hC0;
   localparam logic [7:0] IDENT_TAIL   = 8'h80;

   typedef enum logic [2:0] {
      KIND_DASH    = 3'd0,
      KIND_EQUAL   = 3'd1,
      KIND_SEMI    = 3'd2,
      KIND_IDENT   = 3'd3,
      KIND_INT     = 3'd4,
      KIND_UNKNOWN = 3'd5,
      KIND_END     = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_IDENT = 3'b010,
      MODE_INT   = 3'b100
   } mode_type;

   typedef struct packed {
      kind_type                  kind;
      logic [POSITION_WIDTH-1:0] line;
      logic [POSITION_WIDTH-1:0] column;
      logic [OFFSET_WIDTH-1:0]   start;
      logic [POSITION_WIDTH-1:0] length;
      logic                      last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

endpackage

>>> rtl/tlc_scan.sv
// Scanner: position counters, pending run token and token classification.
`timescale 1ns / 1ps

module tlc_scan import tlc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] source_byte,
   input  logic       end_of_source,
   output push_type   push
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
   localparam logic [OFFSET_WIDTH-1:0]   OFF_MAX = '1;
   localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

   mode_type                  mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] line_ff, line_in;
   logic [POSITION_WIDTH-1:0] column_ff, column_in;
   logic [OFFSET_WIDTH-1:0]   offset_ff, offset_in;
   logic [POSITION_WIDTH-1:0] pend_line_ff, pend_line_in;
   logic [POSITION_WIDTH-1:0] pend_column_ff, pend_column_in;
   logic [OFFSET_WIDTH-1:0]   pend_start_ff, pend_start_in;
   logic [POSITION_WIDTH-1:0] pend_length_ff, pend_length_in;

   logic      is_letter, is_digit, is_skip, is_start, is_newline;
   logic      extend, pending, emit_run, emit_other;
   kind_type  single_kind;
   token_type run_tok, other_tok;

   function automatic logic [POSITION_WIDTH-1:0] sat_inc(input logic [POSITION_WIDTH-1:0] x);
      return (x == POS_MAX) ? x : x + POS_ONE;
   endfunction

   always_comb begin
      is_letter  = (source_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
      is_digit   = (source_byte inside {[8'h30:8'h39]});
      is_newline = (source_byte == CHAR_NEWLINE);
      is_skip    = (source_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE});
      is_start   = is_letter || is_digit || (source_byte >= IDENT_LEAD);
      pending    = (mode_ff != MODE_IDLE);
      extend     = ((mode_ff == MODE_IDENT) &&
                    (is_letter || is_digit || (source_byte >= IDENT_TAIL))) ||
                   ((mode_ff == MODE_INT) && is_digit);

      case (source_byte)
         CHAR_DASH:  single_kind = KIND_DASH;
         CHAR_EQUAL: single_kind = KIND_EQUAL;
         CHAR_SEMI:  single_kind = KIND_SEMI;
         default:    single_kind = KIND_UNKNOWN;
      endcase

      emit_run   = pending && (end_of_source || !extend);
      emit_other = end_of_source || (!extend && !is_skip && !is_start);

      run_tok.kind   = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_INT;
      run_tok.line   = pend_line_ff;
      run_tok.column = pend_column_ff;
      run_tok.start  = pend_start_ff;
      run_tok.length = pend_length_ff;
      run_tok.last   = !emit_other;

      other_tok.kind   = end_of_source ? KIND_END : single_kind;
      other_tok.line   = line_ff;
      other_tok.column = column_ff;
      other_tok.start  = offset_ff;
      other_tok.length = POS_ONE;
      other_tok.last   = 1'b1;

      push.first  = emit_run ? run_tok : other_tok;
      push.second = other_tok;
      push.count  = fire ? (2'(emit_run) + 2'(emit_other)) : 2'd0;
   end

   always_comb begin
      mode_in        = mode_ff;
      line_in        = line_ff;
      column_in      = column_ff;
      offset_in      = offset_ff;
      pend_line_in   = pend_line_ff;
      pend_column_in = pend_column_ff;
      pend_start_in  = pend_start_ff;
      pend_length_in = pend_length_ff;
      if (end_of_source) begin
         mode_in        = MODE_IDLE;
         line_in        = POS_ONE;
         column_in      = POS_ONE;
         offset_in      = '0;
         pend_line_in   = POS_ONE;
         pend_column_in = POS_ONE;
         pend_start_in  = '0;
         pend_length_in = '0;
      end else begin
         if (extend) begin
            pend_length_in = sat_inc(pend_length_ff);
         end else if (is_start) begin
            mode_in        = is_digit ? MODE_INT : MODE_IDENT;
            pend_line_in   = line_ff;
            pend_column_in = column_ff;
            pend_start_in  = offset_ff;
            pend_length_in = POS_ONE;
         end else begin
            mode_in = MODE_IDLE;
         end
         offset_in = (offset_ff == OFF_MAX) ? offset_ff : offset_ff + OFFSET_WIDTH'(1);
         if (is_newline) begin
            line_in   = sat_inc(line_ff);
            column_in = POS_ONE;
         end else begin
            column_in = sat_inc(column_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         line_ff        <= POS_ONE;
         column_ff      <= POS_ONE;
         offset_ff      <= '0;
         pend_line_ff   <= POS_ONE;
         pend_column_ff <= POS_ONE;
         pend_start_ff  <= '0;
         pend_length_ff <= '0;
      end else if (fire) begin
         mode_ff        <= mode_in;
         line_ff        <= line_in;
         column_ff      <= column_in;
         offset_ff      <= offset_in;
         pend_line_ff   <= pend_line_in;
         pend_column_ff <= pend_column_in;
         pend_start_ff  <= pend_start_in;
         pend_length_ff <= pend_length_in;
      end
   end

endmodule

>>> rtl/tlc_rsp_queue.sv
// Result queue: takes up to two tokens per cycle, hands out one per cycle while the reader is ready.
`timescale 1ns / 1ps

module tlc_rsp_queue import tlc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      room,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_tok
);

   token_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic [QPTR_WIDTH-1:0]   wr_next;
   logic                    pop;

   always_comb begin
      out_valid = (count_ff != '0);
      out_tok   = entry_ff[rd_ptr_ff];
      room      = (count_ff <= QCNT_WIDTH'(QUEUE_DEPTH - 2));
      pop       = out_valid && out_ready;
      wr_next   = wr_ptr_ff + QPTR_WIDTH'(1);
      wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(pop);
      count_in  = count_ff + QCNT_WIDTH'(push.count) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

>>> rtl/token_lexer_with_line_column.sv
// Top level of the streaming token lexer with line and column tracking.
//
//   channel | direction | handshake             | word
//   req_    | in        | req_valid / req_ready | source byte, end marker
//   rsp_    | out       | rsp_valid / rsp_ready | kind, line, column, start, length, last
//
// A byte is taken into the input register, scanned from there once the queue has
// room, and its tokens written to a four-word result queue. One byte per cycle is
// sustained while the queue drains; a byte that yields two tokens writes two words
// to the queue, and the scan stage waits while the queue holds more than two words.
// Synchronous reset returns to line 1, column 1, offset 0 and empties the queue.
`timescale 1ns / 1ps

module token_lexer_with_line_column import tlc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_source_byte,
   input  logic                      req_end_of_source,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_token_kind,
   output logic [POSITION_WIDTH-1:0] rsp_token_line,
   output logic [POSITION_WIDTH-1:0] rsp_token_column,
   output logic [OFFSET_WIDTH-1:0]   rsp_token_start,
   output logic [POSITION_WIDTH-1:0] rsp_token_length,
   output logic                      rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       room, scan_fire;
   push_type   push;
   token_type  out_tok;

   assign scan_fire   = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || scan_fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !scan_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_source_byte;
         in_end_ff  <= req_end_of_source;
      end
   end

   tlc_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .fire          (scan_fire),
      .source_byte   (in_byte_ff),
      .end_of_source (in_end_ff),
      .push          (push)
   );

   tlc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_tok   (out_tok)
   );

   assign rsp_token_kind   = out_tok.kind;
   assign rsp_token_line   = out_tok.line;
   assign rsp_token_column = out_tok.column;
   assign rsp_token_start  = out_tok.start;
   assign rsp_token_length = out_tok.length;
   assign rsp_last_of_run  = out_tok.last;

endmodule

>>> tb/lexer_token_checker.sv
// Token checker for the lexer: predicts tokens from accepted bytes and compares results.
`timescale 1ns / 1ps

module lexer_token_checker import tlc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [7:0]                req_source_byte,
   input  logic                      req_end_of_source,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [2:0]                rsp_token_kind,
   input  logic [POSITION_WIDTH-1:0] rsp_token_line,
   input  logic [POSITION_WIDTH-1:0] rsp_token_column,
   input  logic [OFFSET_WIDTH-1:0]   rsp_token_start,
   input  logic [POSITION_WIDTH-1:0] rsp_token_length,
   input  logic                      rsp_last_of_run,
   output int                        outstanding,
   output int                        mismatch_count,
   output int                        tokens_checked
);

   mode_type                  scan_state;
   logic [POSITION_WIDTH-1:0] line_now;
   logic [POSITION_WIDTH-1:0] column_now;
   logic [OFFSET_WIDTH-1:0]   offset_now;
   logic [POSITION_WIDTH-1:0] run_line;
   logic [POSITION_WIDTH-1:0] run_column;
   logic [OFFSET_WIDTH-1:0]   run_start;
   logic [POSITION_WIDTH-1:0] run_length;
   token_type                 expected_tokens[$];
   token_type                 oldest;

   function automatic logic [POSITION_WIDTH-1:0] saturating_inc(
      input logic [POSITION_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   task automatic restart_scan();
      scan_state = MODE_IDLE;
      line_now   = 1;
      column_now = 1;
      offset_now = 0;
      run_line   = 1;
      run_column = 1;
      run_start  = 0;
      run_length = 0;
   endtask

   task automatic scan_word(input logic [7:0] b, input logic eos);
      token_type run_tok;
      token_type one_tok;
      logic      run_done;
      logic      one_done;
      logic      letter;
      logic      digit;
      letter   = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
      digit    = b >= 8'h30 && b <= 8'h39;
      run_done = 1'b0;
      one_done = 1'b0;
      run_tok  = '0;
      one_tok  = '0;
      if (scan_state != MODE_IDLE) begin
         run_tok.kind   = (scan_state == MODE_IDENT) ? KIND_IDENT : KIND_INT;
         run_tok.line   = run_line;
         run_tok.column = run_column;
         run_tok.start  = run_start;
         run_tok.length = run_length;
         run_tok.last   = 1'b1;
      end
      if (eos) begin
         run_done       = scan_state != MODE_IDLE;
         run_tok.last   = 1'b0;
         one_tok.kind   = KIND_END;
         one_tok.line   = line_now;
         one_tok.column = column_now;
         one_tok.start  = offset_now;
         one_tok.length = 1;
         one_tok.last   = 1'b1;
         one_done       = 1'b1;
         restart_scan();
      end else if ((scan_state == MODE_IDENT && (letter || digit || b >= IDENT_TAIL)) ||
                   (scan_state == MODE_INT && digit)) begin
         run_length = saturating_inc(run_length);
      end else begin
         run_done   = scan_state != MODE_IDLE;
         scan_state = MODE_IDLE;
         if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE) begin
         end else if (letter || digit || b >= IDENT_LEAD) begin
            scan_state = digit ? MODE_INT : MODE_IDENT;
            run_line   = line_now;
            run_column = column_now;
            run_start  = offset_now;
            run_length = 1;
         end else begin
            case (b)
               CHAR_DASH:  one_tok.kind = KIND_DASH;
               CHAR_EQUAL: one_tok.kind = KIND_EQUAL;
               CHAR_SEMI:  one_tok.kind = KIND_SEMI;
               default:    one_tok.kind = KIND_UNKNOWN;
            endcase
            one_tok.line   = line_now;
            one_tok.column = column_now;
            one_tok.start  = offset_now;
            one_tok.length = 1;
            one_tok.last   = 1'b1;
            one_done       = 1'b1;
            run_tok.last   = 1'b0;
         end
      end
      if (!eos) begin
         if (offset_now != '1) offset_now = offset_now + 1'b1;
         if (b == CHAR_NEWLINE) begin
            line_now   = saturating_inc(line_now);
            column_now = 1;
         end else begin
            column_now = saturating_inc(column_now);
         end
      end
      if (run_done) expected_tokens.push_back(run_tok);
      if (one_done) expected_tokens.push_back(one_tok);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_scan();
         expected_tokens.delete();
         mismatch_count = 0;
         tokens_checked = 0;
      end else begin
         if (req_valid && req_ready) scan_word(req_source_byte, req_end_of_source);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token_kind mismatch: expected none, got %0d", rsp_token_kind);
               mismatch_count++;
            end else begin
               oldest = expected_tokens.pop_front();
               compare_field("token_kind", 32'(oldest.kind), 32'(rsp_token_kind));
               compare_field("token_line", 32'(oldest.line), 32'(rsp_token_line));
               compare_field("token_column", 32'(oldest.column), 32'(rsp_token_column));
               compare_field("token_start", oldest.start, rsp_token_start);
               compare_field("token_length", 32'(oldest.length), 32'(rsp_token_length));
               compare_field("last_of_run", 32'(oldest.last), 32'(rsp_last_of_run));
               tokens_checked++;
            end
         end
      end
      outstanding <= expected_tokens.size();
   end

endmodule

>>> tb/token_lexer_with_line_column_tb.sv
// Testbench top for the token lexer: byte stimulus, result pacing and verdict.
`timescale 1ns / 1ps

module token_lexer_with_line_column_tb import tlc_pkg::*;;

   localparam int         LIMIT       = 2_000_000;
   localparam int         HOLD_CYCLES = 200;
   localparam logic [8:0] END_MARK    = 9'h100;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_source_byte   = 8'h00;
   logic                      req_end_of_source = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready         = 1'b0;
   logic [2:0]                rsp_token_kind;
   logic [POSITION_WIDTH-1:0] rsp_token_line;
   logic [POSITION_WIDTH-1:0] rsp_token_column;
   logic [OFFSET_WIDTH-1:0]   rsp_token_start;
   logic [POSITION_WIDTH-1:0] rsp_token_length;
   logic                      rsp_last_of_run;

   int   outstanding;
   int   mismatch_count;
   int   tokens_checked;
   int   words_sent   = 0;
   int   texts_ended  = 0;
   int   send_pct     = 0;
   int   stall_pct    = 0;
   int   cycle_count  = 0;
   logic hold_trigger = 1'b0;

   logic [8:0] opening [0:24] = '{
      9'h041, 9'h07A, 9'h030, 9'h039, 9'h0FF, 9'h080, 9'h02D,
      9'h030, 9'h039, 9'h03B,
      9'h0C0, 9'h061, 9'h020,
      9'h080, 9'h0BF, 9'h03D,
      9'h009, 9'h00A, 9'h05A, 9'h00A,
      9'h000, 9'h035, 9'h071, END_MARK,
      END_MARK
   };

   always #2 clock = ~clock;

   token_lexer_with_line_column u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_byte   (req_source_byte),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_token_line    (rsp_token_line),
      .rsp_token_column  (rsp_token_column),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   lexer_token_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_byte   (req_source_byte),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_token_line    (rsp_token_line),
      .rsp_token_column  (rsp_token_column),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_last_of_run   (rsp_last_of_run),
      .outstanding       (outstanding),
      .mismatch_count    (mismatch_count),
      .tokens_checked    (tokens_checked)
   );

   function automatic logic [7:0] random_letter();
      return $urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 25))
                                  : 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   task automatic send_word(input logic [7:0] b, input logic eos);
      req_valid         <= 1'b1;
      req_source_byte   <= b;
      req_end_of_source <= eos;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (eos) texts_ended++;
      if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_lexeme();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         n = $urandom_range(0, 9);
         send_word($urandom_range(0, 3) == 0 ? 8'($urandom_range(8'hC0, 8'hFF))
                                             : random_letter(), 1'b0);
         repeat (n) begin
            case ($urandom_range(0, 2))
               0:       send_word(random_letter(), 1'b0);
               1:       send_word(random_digit(), 1'b0);
               default: send_word(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
            endcase
         end
      end else if (pick < 45) begin
         repeat ($urandom_range(1, 8)) send_word(random_digit(), 1'b0);
      end else if (pick < 60) begin
         case ($urandom_range(0, 2))
            0:       send_word(CHAR_DASH, 1'b0);
            1:       send_word(CHAR_EQUAL, 1'b0);
            default: send_word(CHAR_SEMI, 1'b0);
         endcase
      end else if (pick < 80) begin
         case ($urandom_range(0, 2))
            0:       send_word(CHAR_SPACE, 1'b0);
            1:       send_word(CHAR_TAB, 1'b0);
            default: send_word(CHAR_NEWLINE, 1'b0);
         endcase
      end else if (pick < 97) begin
         send_word(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         send_word(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stall_pct = 20;
      foreach (opening[i]) send_word(opening[i][7:0], opening[i][8]);
      wait_for_drain();

      // hold the result side while bytes keep coming
      send_pct     = 0;
      hold_trigger = 1'b1;
      repeat (40) send_lexeme();
      wait_for_drain();

      for (int phase = 0; phase < 6; phase++) begin
         send_pct  = (phase % 3) * 8;
         stall_pct = ((phase + 1) % 3) * 10;
         target    = words_sent + 260;
         while (words_sent < target) send_lexeme();
      end

      send_pct  = 0;
      stall_pct = 0;
      target = words_sent + 200;
      while (words_sent < target) send_lexeme();
      send_word(8'($urandom_range(0, 255)), 1'b1);

      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("Scanned %0d source bytes over %0d texts, with stalls on both sides,",
               words_sent, texts_ended);
      $display("a long result hold-off and full drains; %0d tokens matched.",
               tokens_checked);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/tlc_pkg.sv
rtl/tlc_scan.sv
rtl/tlc_rsp_queue.sv
rtl/token_lexer_with_line_column.sv
tb/lexer_token_checker.sv
tb/token_lexer_with_line_column_tb.sv
